@@ rtl/pva_pkg.sv @@
// Shared constants, widths and the arctangent table of the polar vector adder.
package pva_pkg;

    localparam int unsigned ROT_STEPS_DEF = 16;
    localparam int unsigned TAB_SIZE      = 24;

    localparam int LEN_W = 16;
    localparam int ANG_W = 17;
    localparam int MAG_W = 17;
    localparam int DIR_W = 16;

    // rotation datapath: parts, angle accumulator
    localparam int XR_W = 30;
    localparam int ZR_W = 29;
    // vectoring datapath
    localparam int XV_W = 32;
    localparam int ZV_W = 30;
    localparam int PROD_W = 63;
    localparam int ATAN_W = 27;

    localparam logic [31:0] INVK_Q32 = 32'd2608131496;
    localparam int HALF_TURN = 23040;
    localparam int QUARTER_TURN = 11520;
    localparam int DIR_MAX = 23040;
    localparam int MAG_MAX = 131070;
    localparam int ANG_SHIFT = 13;
    localparam int MAG_SHIFT = 44;
    localparam logic signed [ZV_W-1:0] BASE_Z = 30'sd188743680;

    function automatic logic [ATAN_W-1:0] atan_val(input logic [4:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:  v = 27'd47185920;
            5'd1:  v = 27'd27855475;
            5'd2:  v = 27'd14718068;
            5'd3:  v = 27'd7471121;
            5'd4:  v = 27'd3750058;
            5'd5:  v = 27'd1876857;
            5'd6:  v = 27'd938658;
            5'd7:  v = 27'd469357;
            5'd8:  v = 27'd234682;
            5'd9:  v = 27'd117342;
            5'd10: v = 27'd58671;
            5'd11: v = 27'd29335;
            5'd12: v = 27'd14668;
            5'd13: v = 27'd7334;
            5'd14: v = 27'd3667;
            5'd15: v = 27'd1833;
            5'd16: v = 27'd917;
            5'd17: v = 27'd458;
            5'd18: v = 27'd229;
            5'd19: v = 27'd115;
            5'd20: v = 27'd57;
            5'd21: v = 27'd29;
            5'd22: v = 27'd14;
            5'd23: v = 27'd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/pva_if.sv @@
// Valid/ready channel interfaces for the vector pair input and the polar result.
interface pva_in_if import pva_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic        [LEN_W-1:0] first_length;
    logic signed [ANG_W-1:0] first_angle;
    logic        [LEN_W-1:0] second_length;
    logic signed [ANG_W-1:0] second_angle;

    modport source (output valid, first_length, first_angle, second_length, second_angle,
                    input ready);
    modport sink   (input valid, first_length, first_angle, second_length, second_angle,
                    output ready);
endinterface

interface pva_out_if import pva_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic        [MAG_W-1:0] sum_magnitude;
    logic signed [DIR_W-1:0] sum_direction;

    modport source (output valid, sum_magnitude, sum_direction, input ready);
    modport sink   (input valid, sum_magnitude, sum_direction, output ready);
endinterface

@@ rtl/polar_vector_adder.sv @@
// Polar vector adder: CORDIC pipeline that sums two polar vectors.
//
// Usage:
//  - i_in carries one transaction per vector pair: two lengths (unsigned,
//    1/16 units) and two directions (signed, 1/128 degree, any 17-bit value).
//  - o_out returns one transaction per pair: the magnitude of the sum
//    (1/16 units) and its direction (1/128 degree, -180..+180 degrees).
//    A null resultant reports magnitude 0 and direction 0.
//  - Throughput is one transaction per cycle while o_out is not stalled:
//    every stage is a register slice with its own valid bit; each rotation
//    and vectoring stage runs one CORDIC iteration, first rotating both
//    vectors, then vectoring their sum.
//  - When the receiver stalls, the output stage holds; earlier stages keep
//    advancing into empty slots, so the input keeps taking transactions
//    until the pipeline is full. Nothing is dropped or repeated.
//  - Reset (synchronous, active low) empties all stages; payload registers
//    are not cleared.
module polar_vector_adder import pva_pkg::*; #(
    parameter int unsigned ROTATION_STEPS = ROT_STEPS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pva_in_if.sink    i_in,
    pva_out_if.source o_out
);

    // the arctangent table bounds the number of iterations
    localparam int unsigned N = (ROTATION_STEPS < TAB_SIZE) ? ROTATION_STEPS : TAB_SIZE;
    // stage map: 0 prep, 1..N rotate, N+1 sum, N+2 fold, N+3..2N+2 vector,
    // 2N+3 multiply, 2N+4 output
    localparam int unsigned L = 2 * N + 5;
    localparam int unsigned S_SUM  = N + 1;
    localparam int unsigned S_FOLD = N + 2;
    localparam int unsigned S_MUL  = 2 * N + 3;
    localparam int unsigned S_OUT  = 2 * N + 4;

    typedef struct packed {
        logic signed [XR_W-1:0] x;
        logic signed [XR_W-1:0] y;
        logic signed [ZR_W-1:0] z;
        logic                   flip;
    } t_rot;

    typedef struct packed {
        logic signed [XV_W-1:0] x;
        logic signed [XV_W-1:0] y;
        logic signed [ZV_W-1:0] z;
        logic                   nul;
    } t_vec;

    // Reduce the angle into [-180,180), fold to +-90, and scale the length by 1/K.
    function automatic t_rot prep(input logic [LEN_W-1:0] len,
                                  input logic signed [ANG_W-1:0] ang);
        t_rot               s;
        logic signed [17:0] r;
        logic        [48:0] p;
        r = 18'(ang);
        s.flip = 1'b0;
        if (r >= 18'sd23040) begin
            r = r - 18'sd46080;
        end else if (r < -18'sd23040) begin
            r = r + 18'sd46080;
        end
        if (r > 18'sd11520) begin
            r = r - 18'sd23040;
            s.flip = 1'b1;
        end else if (r < -18'sd11520) begin
            r = r + 18'sd23040;
            s.flip = 1'b1;
        end
        p = 49'(len) * 49'(INVK_Q32) + 49'(1 << 19);
        s.x = $signed({1'b0, p[48:20]});
        s.y = '0;
        s.z = ZR_W'(r) <<< ANG_SHIFT;
        return s;
    endfunction

    function automatic t_rot rot_step(input t_rot s, input int unsigned i);
        t_rot                   o;
        logic signed [XR_W-1:0] sx;
        logic signed [XR_W-1:0] sy;
        logic signed [ZR_W-1:0] a;
        sx = s.x >>> i;
        sy = s.y >>> i;
        a  = $signed({2'b00, atan_val(5'(i))});
        o.flip = s.flip;
        if (s.z >= 0) begin
            o.x = s.x - sy;
            o.y = s.y + sx;
            o.z = s.z - a;
        end else begin
            o.x = s.x + sy;
            o.y = s.y - sx;
            o.z = s.z + a;
        end
        return o;
    endfunction

    function automatic t_vec vec_step(input t_vec s, input int unsigned i);
        t_vec                   o;
        logic signed [XV_W-1:0] sx;
        logic signed [XV_W-1:0] sy;
        logic signed [ZV_W-1:0] a;
        sx = s.x >>> i;
        sy = s.y >>> i;
        a  = $signed({3'b000, atan_val(5'(i))});
        o.nul = s.nul;
        if (s.y >= 0) begin
            o.x = s.x + sy;
            o.y = s.y - sx;
            o.z = s.z + a;
        end else begin
            o.x = s.x - sy;
            o.y = s.y + sx;
            o.z = s.z - a;
        end
        return o;
    endfunction

    logic [L-1:0] r_vld;
    logic [L-1:0] en;

    t_rot r_ra [N+1];
    t_rot r_rb [N+1];
    logic signed [XV_W-1:0] r_sx;
    logic signed [XV_W-1:0] r_sy;
    t_vec r_v [N+1];
    logic        [PROD_W-1:0] r_prod;
    logic signed [DIR_W-1:0]  r_dir_m;
    logic                     r_nul_m;
    logic        [MAG_W-1:0]  r_mag;
    logic signed [DIR_W-1:0]  r_dir;

    logic signed [XV_W-1:0] n_xa, n_ya, n_xb, n_yb;
    t_vec                   n_fold;
    logic signed [ZV_W:0]   n_zr;
    logic signed [17:0]     n_dsh;
    logic        [63:0]     n_mr;

    // A stage advances when it is empty or its successor advances.
    always_comb begin
        en[L-1] = !r_vld[L-1] || o_out.ready;
        for (int k = int'(L) - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < int'(L); k++) begin
                if (en[k]) begin
                    r_vld[k] <= (k == 0) ? i_in.valid : r_vld[k-1];
                end
            end
        end
    end

    // Prep stage
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_ra[0] <= prep(i_in.first_length, i_in.first_angle);
            r_rb[0] <= prep(i_in.second_length, i_in.second_angle);
        end
    end

    // Rotation stages, one iteration each
    for (genvar j = 0; j < N; j++) begin : g_rot
        always_ff @(posedge i_clk) begin
            if (en[j+1]) begin
                r_ra[j+1] <= rot_step(r_ra[j], j);
                r_rb[j+1] <= rot_step(r_rb[j], j);
            end
        end
    end

    // Sum stage: undo the fold, add the parts
    always_comb begin
        n_xa = XV_W'(r_ra[N].x);
        n_ya = XV_W'(r_ra[N].y);
        n_xb = XV_W'(r_rb[N].x);
        n_yb = XV_W'(r_rb[N].y);
        if (r_ra[N].flip) begin
            n_xa = -n_xa;
            n_ya = -n_ya;
        end
        if (r_rb[N].flip) begin
            n_xb = -n_xb;
            n_yb = -n_yb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[S_SUM]) begin
            r_sx <= n_xa + n_xb;
            r_sy <= n_ya + n_yb;
        end
    end

    // Fold stage: move the left half plane to the right, seed the angle
    always_comb begin
        n_fold.nul = (r_sx == 0) && (r_sy == 0);
        n_fold.x   = r_sx;
        n_fold.y   = r_sy;
        n_fold.z   = '0;
        if (r_sx < 0) begin
            n_fold.x = -r_sx;
            n_fold.y = -r_sy;
            n_fold.z = (r_sy >= 0) ? BASE_Z : -BASE_Z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[S_FOLD]) begin
            r_v[0] <= n_fold;
        end
    end

    for (genvar j = 0; j < N; j++) begin : g_vec
        always_ff @(posedge i_clk) begin
            if (en[S_FOLD+1+j]) begin
                r_v[j+1] <= vec_step(r_v[j], j);
            end
        end
    end

    // Multiply stage: gain correction of the magnitude, round and clamp the direction
    always_comb begin
        n_zr  = (ZV_W+1)'(r_v[N].z) + (ZV_W+1)'(1 << (ANG_SHIFT - 1));
        n_dsh = 18'(n_zr >>> ANG_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (en[S_MUL]) begin
            r_prod  <= PROD_W'(r_v[N].x[XV_W-2:0]) * PROD_W'(INVK_Q32);
            r_nul_m <= r_v[N].nul;
            if (n_dsh > DIR_MAX) begin
                r_dir_m <= DIR_W'(DIR_MAX);
            end else if (n_dsh < -DIR_MAX) begin
                r_dir_m <= -DIR_W'(DIR_MAX);
            end else begin
                r_dir_m <= DIR_W'(n_dsh);
            end
        end
    end

    // Output stage: round and clamp the magnitude, report a null result as zero
    assign n_mr = 64'(r_prod) + (64'd1 << (MAG_SHIFT - 1));

    always_ff @(posedge i_clk) begin
        if (en[S_OUT]) begin
            if (r_nul_m) begin
                r_mag <= '0;
                r_dir <= '0;
            end else begin
                r_mag <= (n_mr[63:MAG_SHIFT] > 20'(MAG_MAX)) ? MAG_W'(MAG_MAX)
                                                           : MAG_W'(n_mr[63:MAG_SHIFT]);
                r_dir <= r_dir_m;
            end
        end
    end

    assign i_in.ready          = en[0];
    assign o_out.valid         = r_vld[L-1];
    assign o_out.sum_magnitude = r_mag;
    assign o_out.sum_direction = r_dir;

    a_mag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[L-1] |-> (r_mag <= MAG_W'(MAG_MAX)))
        else $error("magnitude above clamp");

    a_dir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[L-1] |-> ((r_dir <= DIR_MAX) && (r_dir >= -DIR_MAX)))
        else $error("direction out of range");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_vld[0])
        else $error("accepted transaction lost at first stage");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[L-1] && !o_out.ready && r_vld[L-2]) |=> (r_vld[L-1] && r_vld[L-2]))
        else $error("stalled stage dropped a transaction");

endmodule
